FILE: rtl/command_frame_deframer_top_macros.svh
// Assertion macros shared by the deframer RTL.
`ifndef COMMAND_FRAME_DEFRAMER_TOP_MACROS_SVH
`define COMMAND_FRAME_DEFRAMER_TOP_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define CFD_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define CFD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: rtl/cfd_pkg.sv
// Types and constants for the command frame deframer.
package cfd_pkg;

   // Byte role codes reported on the result channel
   localparam logic [2:0] ROLE_START   = 3'd0;
   localparam logic [2:0] ROLE_KEY     = 3'd1;
   localparam logic [2:0] ROLE_COUNT   = 3'd2;
   localparam logic [2:0] ROLE_HEADER  = 3'd3;
   localparam logic [2:0] ROLE_PAYLOAD = 3'd4;
   localparam logic [2:0] ROLE_TRAILER = 3'd5;

   // Frame layout
   localparam int LEAD_BYTES      = 2;
   localparam int TAIL_BYTES      = 2;
   localparam int MIN_FRAME_BYTES = LEAD_BYTES + 2 + TAIL_BYTES;

   localparam logic [15:0] POS_MAX = 16'hFFFF;

   // One result item
   typedef struct packed {
      logic [2:0] byte_role;
      logic [7:0] argument_number;
      logic       frame_end;
      logic       frame_ok;
      logic [7:0] command_key;
      logic [7:0] argument_count;
   } rsp_type;

endpackage

FILE: rtl/command_frame_deframer_top.sv
// Command frame deframer: per-byte role tagging and frame structure check.
`include "command_frame_deframer_top_macros.svh"

// Command frame deframer. Takes one frame byte per request (req_tdata), with req_tlast on
// the final byte, and returns one response per byte: its role (start, key, count,
// argument header, argument payload, trailer/excess) on rsp_tuser, the argument it belongs
// to, the frame's key and argument count, and on the last byte (rsp_tlast) whether the
// frame was well formed. Throughput is one byte per clock while req_tready is high. The
// parser state updates in the cycle a byte is accepted, so the only loop is the state
// update. The response side has an output register plus a one-entry skid register, so
// req_tready is registered and requests keep flowing while a response waits; req_tready
// drops only once both entries are full. Start and trailer byte values are not checked.
// Frames past 65535 bytes are flagged bad.
module command_frame_deframer_top #(
   parameter int ARG_HEADER_BYTES   = 2,  // bytes per argument header, 1..8
   parameter int SIZE_BYTE_POSITION = 1   // header byte holding payload size, 0..7
) (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] data_byte
   input  logic        req_tlast,   // last_byte
   // response channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [7:0] argument_number, [8] frame_ok,
                                    // [16:9] command_key, [24:17] argument_count,
                                    // [31:25] zero
   output logic [2:0]  rsp_tuser,   // [2:0] byte_role
   output logic        rsp_tlast    // frame_end
);

   // Parser phases
   localparam logic [2:0] PH_START   = 3'd0;
   localparam logic [2:0] PH_KEY     = 3'd1;
   localparam logic [2:0] PH_COUNT   = 3'd2;
   localparam logic [2:0] PH_HEADER  = 3'd3;
   localparam logic [2:0] PH_PAYLOAD = 3'd4;
   localparam logic [2:0] PH_TRAILER = 3'd5;

   // Header byte that carries the payload size; clamps to the last header byte
   localparam int SIZE_AT_INT = (SIZE_BYTE_POSITION < ARG_HEADER_BYTES) ?
                                SIZE_BYTE_POSITION : ARG_HEADER_BYTES - 1;
   localparam logic [8:0]  SIZE_AT   = 9'(SIZE_AT_INT);
   localparam logic [8:0]  HDR_LEN   = 9'(ARG_HEADER_BYTES);
   localparam logic [15:0] START_POS = 16'(cfd_pkg::LEAD_BYTES - 1);
   localparam logic [15:0] OK_POS    = 16'(cfd_pkg::MIN_FRAME_BYTES - 1);
   localparam logic [1:0]  END_LEN   = 2'(cfd_pkg::TAIL_BYTES);

   // Parser state
   logic [2:0]  phase_ff,  phase_in;
   logic [15:0] pos_ff,    pos_in;
   logic [7:0]  done_ff,   done_in;
   logic [8:0]  idx_ff,    idx_in;
   logic [7:0]  size_ff,   size_in;
   logic [7:0]  key_ff,    key_in;
   logic [7:0]  count_ff,  count_in;
   logic [1:0]  trail_ff,  trail_in;
   logic        broken_ff, broken_in;

   // Response buffering
   logic                 out_vld_ff,  out_vld_in;
   logic                 skid_vld_ff, skid_vld_in;
   cfd_pkg::rsp_type     out_ff,      out_in;
   cfd_pkg::rsp_type     skid_ff,     skid_in;
   cfd_pkg::rsp_type     rsp;

   logic       accept;
   logic       take;
   logic       pos_sat;
   logic       broken_now;
   logic [8:0] idx_inc;
   logic [7:0] done_inc;
   logic [2:0] fin_phase;
   logic [7:0] size_hdr;
   logic [2:0] phase_nx;
   logic [1:0] trail_nx;

   assign req_tready = !skid_vld_ff;
   assign accept     = req_tvalid && req_tready;
   assign take       = out_vld_ff && rsp_tready;

   // Parser next state and result for the byte at the input
   always_comb begin
      pos_sat    = (pos_ff == cfd_pkg::POS_MAX);
      broken_now = broken_ff || pos_sat;
      idx_inc    = idx_ff + 9'd1;
      done_inc   = done_ff + 8'd1;
      fin_phase  = (done_inc == count_ff) ? PH_TRAILER : PH_HEADER;
      size_hdr   = (idx_ff == SIZE_AT) ? req_tdata : size_ff;

      phase_nx = phase_ff;
      done_in  = done_ff;
      idx_in   = idx_ff;
      size_in  = size_ff;
      key_in   = key_ff;
      count_in = count_ff;
      trail_nx = trail_ff;

      rsp.byte_role       = cfd_pkg::ROLE_TRAILER;
      rsp.argument_number = 8'd0;

      unique case (phase_ff)
         PH_START: begin
            rsp.byte_role = cfd_pkg::ROLE_START;
            if (pos_ff >= START_POS) phase_nx = PH_KEY;
         end
         PH_KEY: begin
            rsp.byte_role = cfd_pkg::ROLE_KEY;
            key_in        = req_tdata;
            phase_nx      = PH_COUNT;
         end
         PH_COUNT: begin
            rsp.byte_role = cfd_pkg::ROLE_COUNT;
            count_in      = req_tdata;
            done_in       = 8'd0;
            idx_in        = 9'd0;
            phase_nx      = (req_tdata == 8'd0) ? PH_TRAILER : PH_HEADER;
         end
         PH_HEADER: begin
            rsp.byte_role       = cfd_pkg::ROLE_HEADER;
            rsp.argument_number = done_ff;
            size_in             = size_hdr;
            idx_in              = idx_inc;
            if (idx_inc >= HDR_LEN) begin
               if (size_hdr == 8'd0) begin
                  done_in  = done_inc;
                  idx_in   = 9'd0;
                  size_in  = 8'd0;
                  phase_nx = fin_phase;
               end else begin
                  phase_nx = PH_PAYLOAD;
               end
            end
         end
         PH_PAYLOAD: begin
            rsp.byte_role       = cfd_pkg::ROLE_PAYLOAD;
            rsp.argument_number = done_ff;
            idx_in              = idx_inc;
            if ({1'b0, idx_inc} >= ({1'b0, HDR_LEN} + {2'b00, size_ff})) begin
               done_in  = done_inc;
               idx_in   = 9'd0;
               size_in  = 8'd0;
               phase_nx = fin_phase;
            end
         end
         default: begin
            // trailer and anything past it
            rsp.byte_role = cfd_pkg::ROLE_TRAILER;
            if (trail_ff != 2'd3) trail_nx = trail_ff + 2'd1;
         end
      endcase

      pos_in    = pos_sat ? pos_ff : pos_ff + 16'd1;
      broken_in = broken_now;
      phase_in  = phase_nx;
      trail_in  = trail_nx;

      rsp.frame_end      = req_tlast;
      rsp.frame_ok       = req_tlast && !broken_now && (pos_ff >= OK_POS) &&
                           (phase_nx == PH_TRAILER) && (trail_nx == END_LEN);
      rsp.command_key    = key_in;
      rsp.argument_count = count_in;

      // frame closed: back to the reset state
      if (req_tlast) begin
         phase_in  = PH_START;
         pos_in    = 16'd0;
         done_in   = 8'd0;
         idx_in    = 9'd0;
         size_in   = 8'd0;
         key_in    = 8'd0;
         count_in  = 8'd0;
         trail_in  = 2'd0;
         broken_in = 1'b0;
      end
   end

   // Output register plus skid entry
   always_comb begin
      out_vld_in  = out_vld_ff;
      skid_vld_in = skid_vld_ff;
      out_in      = out_ff;
      skid_in     = skid_ff;
      if (take || !out_vld_ff) begin
         if (skid_vld_ff) begin
            out_in      = skid_ff;
            out_vld_in  = 1'b1;
            skid_vld_in = 1'b0;
         end else begin
            out_in     = rsp;
            out_vld_in = accept;
         end
      end else if (accept) begin
         skid_in     = rsp;
         skid_vld_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_START;
         pos_ff      <= 16'd0;
         done_ff     <= 8'd0;
         idx_ff      <= 9'd0;
         size_ff     <= 8'd0;
         key_ff      <= 8'd0;
         count_ff    <= 8'd0;
         trail_ff    <= 2'd0;
         broken_ff   <= 1'b0;
         out_vld_ff  <= 1'b0;
         skid_vld_ff <= 1'b0;
      end else begin
         if (accept) begin
            phase_ff  <= phase_in;
            pos_ff    <= pos_in;
            done_ff   <= done_in;
            idx_ff    <= idx_in;
            size_ff   <= size_in;
            key_ff    <= key_in;
            count_ff  <= count_in;
            trail_ff  <= trail_in;
            broken_ff <= broken_in;
         end
         out_vld_ff  <= out_vld_in;
         skid_vld_ff <= skid_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign rsp_tvalid = out_vld_ff;
   assign rsp_tuser  = out_ff.byte_role;
   assign rsp_tlast  = out_ff.frame_end;
   assign rsp_tdata  = {7'd0, out_ff.argument_count, out_ff.command_key,
                        out_ff.frame_ok, out_ff.argument_number};

   // Assertions
   `CFD_ASSERT_NOW(a_skid_implies_out, clock, reset, skid_vld_ff, out_vld_ff,
      "skid entry full while output register empty")
   `CFD_ASSERT_NOW(a_ok_only_at_end, clock, reset, rsp_tvalid && rsp_tdata[8], rsp_tlast,
      "frame_ok set on a byte that does not end the frame")
   `CFD_ASSERT_NOW(a_argnum_in_range, clock, reset,
      rsp_tvalid && (rsp_tuser == cfd_pkg::ROLE_HEADER || rsp_tuser == cfd_pkg::ROLE_PAYLOAD),
      rsp_tdata[7:0] < rsp_tdata[24:17],
      "argument number not below declared argument count")
   `CFD_ASSERT_NEXT(a_end_clears, clock, reset, accept && req_tlast,
      phase_ff == PH_START && pos_ff == 16'd0 && broken_ff == 1'b0,
      "parser state not cleared after frame end")

endmodule
